FILE: src/cied_pkg.sv
// Shared types, codes and helpers for the case-insensitive edit distance block.
`default_nettype none
package cied_pkg;

    typedef enum logic [1:0] {
        ACT_LOAD = 2'd0,
        ACT_CMP  = 2'd1,
        ACT_FIN  = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    // Control travelling down the cell chain beside the value lanes.
    typedef struct packed {
        logic       row;   // a DP row (second-string byte) is on the link
        logic       fin;   // finish token; the value lane carries the running result
        logic [7:0] key;   // case-folded second-string byte
    } link_ctl_t;

    localparam logic [7:0] UPPER_A  = 8'h41;
    localparam logic [7:0] UPPER_Z  = 8'h5A;
    localparam logic [7:0] CASE_BIT = 8'h20;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= UPPER_A && c <= UPPER_Z)
        begin
            r = c | CASE_BIT;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: src/cied_cell.sv
// One DP cell: holds one first-string byte and its DP column entry.
`default_nettype none
module cied_cell #(
    parameter int INDEX = 1,
    parameter int VAL_W = 7,
    parameter int LEN_W = 7
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                clear,
    input  logic                load_en,
    input  logic [LEN_W-1:0]    load_idx,
    input  logic [7:0]          load_char,
    input  cied_pkg::link_ctl_t ctl_in,
    input  logic [VAL_W-1:0]    nv_in,
    input  logic [VAL_W-1:0]    old_in,
    output cied_pkg::link_ctl_t ctl_out,
    output logic [VAL_W-1:0]    nv_out,
    output logic [VAL_W-1:0]    old_out
);
    import cied_pkg::*;

    logic [7:0]       char_reg;
    logic             loaded_reg;
    logic [VAL_W-1:0] dp_reg;
    link_ctl_t        ctl_reg;
    logic [VAL_W-1:0] nv_reg;
    logic [VAL_W-1:0] old_reg;

    logic             load_hit;
    logic             match;
    logic [VAL_W-1:0] lo;
    logic [VAL_W-1:0] dp_next;

    assign load_hit = load_en && (load_idx == LEN_W'(INDEX - 1));
    assign match    = (ctl_in.key == char_reg);

    always_comb
    begin
        lo = old_in;
        if (dp_reg < lo)
        begin
            lo = dp_reg;
        end
        if (nv_in < lo)
        begin
            lo = nv_in;
        end
        dp_next = match ? old_in : VAL_W'(lo + 1'b1);
    end

    always_ff @(posedge clk)
    begin
        if (load_hit)
        begin
            char_reg <= fold_case(load_char);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg <= 1'b0;
            dp_reg     <= VAL_W'(INDEX);
            ctl_reg    <= '0;
        end
        else
        begin
            ctl_reg <= ctl_in;
            if (clear)
            begin
                loaded_reg <= 1'b0;
                dp_reg     <= VAL_W'(INDEX);
            end
            else
            begin
                if (load_hit)
                begin
                    loaded_reg <= 1'b1;
                end
                if (ctl_in.row && loaded_reg)
                begin
                    dp_reg <= dp_next;
                end
            end
        end
    end

    // On the finish token, every loaded cell overwrites the running result, so the last loaded cell's entry wins.
    always_ff @(posedge clk)
    begin
        if (ctl_in.fin)
        begin
            nv_reg <= loaded_reg ? dp_reg : nv_in;
        end
        else
        begin
            nv_reg <= dp_next;
        end
        old_reg <= dp_reg;
    end

    assign ctl_out = ctl_reg;
    assign nv_out  = nv_reg;
    assign old_out = old_reg;

endmodule
`default_nettype wire

FILE: src/case_insensitive_edit_distance.sv
// Top level of the case-insensitive edit distance block: input decode, cell chain, result.
`default_nettype none
// Levenshtein distance with ASCII letters folded to lower case. Load transfers
// (tuser = 0) store first-string bytes into a row of MAX_LEN cells; compare
// transfers (tuser = 1) each push one DP row into the chain, which moves one
// cell per cycle, so load and compare transfers are taken one per cycle while
// idle. A finish transfer (tuser = 2) sends a token behind the last row; it
// crosses the head register and all MAX_LEN cells into the result register,
// and the block clears itself and takes the next item once that result sits
// in the output register. Bytes beyond MAX_LEN in either string are dropped
// and raise the overflow flag; loads after the first compare are ignored.
// Action code 3 is ignored.
module case_insensitive_edit_distance #(
    parameter int MAX_LEN = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_code
    input  logic [1:0] s_tuser,   // [1:0] action
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [6:0] distance, [7] zero
    output logic       m_tuser    // [0] overflow
);
    import cied_pkg::*;

    localparam int LEN_W = $clog2(MAX_LEN + 1);

    state_t           state_reg, state_next;
    logic [LEN_W-1:0] first_len_reg;
    logic [LEN_W-1:0] second_len_reg;
    logic             overflow_reg;
    link_ctl_t        head_ctl_reg;
    link_ctl_t        head_ctl_next;
    logic [LEN_W-1:0] head_nv_reg;
    logic [LEN_W-1:0] head_old_reg;
    logic [LEN_W-1:0] res_reg;
    logic             m_valid_reg;
    logic [6:0]       m_dist_reg;
    logic             m_ovf_reg;

    link_ctl_t        ctl_link [0:MAX_LEN];
    logic [LEN_W-1:0] nv_link  [0:MAX_LEN];
    logic [LEN_W-1:0] old_link [0:MAX_LEN];

    action_t action;
    logic    accept;
    logic    emit_go;
    logic    load_en;
    logic    tail_fin;

    assign action   = action_t'(s_tuser);
    assign accept   = s_tvalid && s_tready;
    assign tail_fin = ctl_link[MAX_LEN].fin;
    assign load_en  = accept && (action == ACT_LOAD) && (second_len_reg == '0)
                      && (first_len_reg < LEN_W'(MAX_LEN));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && action == ACT_FIN)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (tail_fin)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        emit_go  = 1'b0;
        unique case (state_reg)
            ST_IDLE:  s_tready = 1'b1;
            ST_DRAIN: s_tready = 1'b0;
            ST_EMIT:  emit_go  = !m_valid_reg || m_tready;
            default:  s_tready = 1'b0;
        endcase
    end

    // Control word entering the chain: a row for a kept compare, a token for finish.
    always_comb
    begin
        head_ctl_next = '0;
        if (accept)
        begin
            if (action == ACT_CMP && second_len_reg < LEN_W'(MAX_LEN))
            begin
                head_ctl_next.row = 1'b1;
                head_ctl_next.key = fold_case(s_tdata);
            end
            if (action == ACT_FIN)
            begin
                head_ctl_next.fin = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            first_len_reg  <= '0;
            second_len_reg <= '0;
            overflow_reg   <= 1'b0;
            head_ctl_reg   <= '0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_ctl_reg <= head_ctl_next;
            if (emit_go)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            if (emit_go)
            begin
                first_len_reg  <= '0;
                second_len_reg <= '0;
                overflow_reg   <= 1'b0;
            end
            else if (accept)
            begin
                case (action)
                    ACT_LOAD:
                    begin
                        if (second_len_reg == '0)
                        begin
                            if (first_len_reg < LEN_W'(MAX_LEN))
                            begin
                                first_len_reg <= first_len_reg + 1'b1;
                            end
                            else
                            begin
                                overflow_reg <= 1'b1;
                            end
                        end
                    end
                    ACT_CMP:
                    begin
                        if (second_len_reg < LEN_W'(MAX_LEN))
                        begin
                            second_len_reg <= second_len_reg + 1'b1;
                        end
                        else
                        begin
                            overflow_reg <= 1'b1;
                        end
                    end
                    ACT_FIN:
                    begin
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Boundary column entry: old value is the row count so far, new is one more.
    // On finish the value lane starts with the result for an empty first string.
    always_ff @(posedge clk)
    begin
        if (accept && action == ACT_FIN)
        begin
            head_nv_reg <= second_len_reg;
        end
        else
        begin
            head_nv_reg <= second_len_reg + 1'b1;
        end
        head_old_reg <= second_len_reg;
        if (tail_fin)
        begin
            res_reg <= nv_link[MAX_LEN];
        end
        if (emit_go)
        begin
            m_dist_reg <= 7'(res_reg);
            m_ovf_reg  <= overflow_reg;
        end
    end

    assign ctl_link[0] = head_ctl_reg;
    assign nv_link[0]  = head_nv_reg;
    assign old_link[0] = head_old_reg;

    for (genvar g = 1; g <= MAX_LEN; g++)
    begin : g_cell
        cied_cell #(
            .INDEX (g),
            .VAL_W (LEN_W),
            .LEN_W (LEN_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .clear     (emit_go),
            .load_en   (load_en),
            .load_idx  (first_len_reg),
            .load_char (s_tdata),
            .ctl_in    (ctl_link[g-1]),
            .nv_in     (nv_link[g-1]),
            .old_in    (old_link[g-1]),
            .ctl_out   (ctl_link[g]),
            .nv_out    (nv_link[g]),
            .old_out   (old_link[g])
        );
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_dist_reg};
    assign m_tuser  = m_ovf_reg;

`ifndef SYNTHESIS
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        first_len_reg <= LEN_W'(MAX_LEN) && second_len_reg <= LEN_W'(MAX_LEN))
        else $error("string length past MAX_LEN");

    a_no_token_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !tail_fin)
        else $error("finish token left the chain while accepting input");

    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        emit_go |=> m_tvalid && state_reg == ST_IDLE && first_len_reg == '0)
        else $error("result not presented after emit");
`endif

endmodule
`default_nettype wire

FILE: verif/edit_distance_checker.sv
// Watches both streams of the edit distance block, predicts each distance and compares it.
module edit_distance_checker #(
    parameter int MAX_LEN = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_code
    input  logic [1:0] s_tuser,   // [1:0] action
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,   // [6:0] distance, [7] zero
    input  logic       m_tuser,   // [0] overflow
    output int         errors,
    output int         pending,
    output int         results_checked,
    output int         overflow_results
);
    import cied_pkg::*;

    typedef struct packed {
        logic [6:0] distance;
        logic       overflow;
    } distance_result_t;

    // Predicted block state
    logic [7:0]       stored_str [MAX_LEN];
    logic [6:0]       column [MAX_LEN + 1];
    int               stored_len;
    int               probe_len;
    logic             overflow_seen;

    distance_result_t expected_distances [$];

    function automatic logic [7:0] lower_letter(input logic [7:0] c);
        if (c >= UPPER_A && c <= UPPER_Z)
        begin
            return c + CASE_BIT;
        end
        return c;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        errors++;
    endtask

    task automatic clear_prediction();
        int i;
        for (i = 0; i <= MAX_LEN; i++)
        begin
            column[i] = 7'(i);
        end
        stored_len    = 0;
        probe_len     = 0;
        overflow_seen = 1'b0;
    endtask

    task automatic take_load(input logic [7:0] ch);
        // Drop loads once the second string has started
        if (probe_len != 0)
        begin
            return;
        end
        if (stored_len >= MAX_LEN)
        begin
            overflow_seen = 1'b1;
            return;
        end
        stored_str[stored_len] = ch;
        stored_len++;
    endtask

    task automatic take_compare(input logic [7:0] ch);
        logic [7:0] key;
        logic [6:0] diag;
        logic [6:0] left;
        logic [6:0] best;
        int         i;
        if (probe_len >= MAX_LEN)
        begin
            overflow_seen = 1'b1;
            return;
        end
        key       = lower_letter(ch);
        diag      = column[0];
        column[0] = 7'(probe_len + 1);
        for (i = 1; i <= stored_len; i++)
        begin
            left = column[i];
            if (lower_letter(stored_str[i - 1]) == key)
            begin
                column[i] = diag;
            end
            else
            begin
                best = diag < left ? diag : left;
                best = best < column[i - 1] ? best : column[i - 1];
                column[i] = best + 7'd1;
            end
            diag = left;
        end
        probe_len++;
    endtask

    task automatic take_finish();
        distance_result_t want;
        want.distance = column[stored_len];
        want.overflow = overflow_seen;
        expected_distances = {expected_distances, want};
        clear_prediction();
    endtask

    task automatic check_result();
        distance_result_t want;
        if (expected_distances.size() == 0)
        begin
            report_mismatch($sformatf("distance %0d overflow %0d arrived with none expected",
                                      m_tdata[6:0], m_tuser));
            return;
        end
        want = expected_distances.pop_front();
        results_checked++;
        if (want.overflow)
        begin
            overflow_results++;
        end
        if (m_tdata[6:0] !== want.distance)
        begin
            report_mismatch($sformatf("distance got %0d want %0d", m_tdata[6:0], want.distance));
        end
        if (m_tuser !== want.overflow)
        begin
            report_mismatch($sformatf("overflow got %0b want %0b", m_tuser, want.overflow));
        end
        if (m_tdata[7] !== 1'b0)
        begin
            report_mismatch($sformatf("tdata pad bit got %0b want 0", m_tdata[7]));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_prediction();
            expected_distances.delete();
            errors           = 0;
            results_checked  = 0;
            overflow_results = 0;
            pending <= 0;
        end
        else
        begin
            // Match the outgoing transfer first: it belongs to an older finish
            if (m_tvalid && m_tready)
            begin
                check_result();
            end
            if (s_tvalid && s_tready)
            begin
                case (s_tuser)
                    ACT_LOAD: take_load(s_tdata);
                    ACT_CMP:  take_compare(s_tdata);
                    ACT_FIN:  take_finish();
                    default:  ;
                endcase
            end
            pending <= expected_distances.size();
        end
    end

endmodule

FILE: verif/case_insensitive_edit_distance_test.sv
// Testbench top for the edit distance block: clock, reset, stimulus, flow control and verdict.
module case_insensitive_edit_distance_test;
    import cied_pkg::*;

    localparam int         MAX_LEN        = 64;
    localparam int         ITEM_TARGET    = 1050;
    localparam int         RX_HOLD_CYCLES = 500;
    localparam int         LIMIT_CYCLES   = 1_000_000;
    localparam logic [1:0] ACT_UNUSED     = 2'd3;

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;   // [7:0] char_code
    logic [1:0] s_tuser;   // [1:0] action
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;   // [6:0] distance, [7] zero
    logic       m_tuser;   // [0] overflow

    int errors;
    int pending;
    int results_checked;
    int overflow_results;

    bit rx_hold_req;
    int burst_left;
    int items_sent;
    int ignored_sent;
    int pairs_sent;

    case_insensitive_edit_distance #(
        .MAX_LEN (MAX_LEN)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    edit_distance_checker #(
        .MAX_LEN (MAX_LEN)
    ) u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tuser          (s_tuser),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .m_tuser          (m_tuser),
        .errors           (errors),
        .pending          (pending),
        .results_checked  (results_checked),
        .overflow_results (overflow_results)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Offer one transfer, opening a new burst after a random gap when the last one ran out
    task automatic put_item(input logic [1:0] act, input logic [7:0] ch, input bit counted);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= ch;
        do @(posedge clk); while (!s_tready);
        if (counted)
        begin
            items_sent++;
        end
        else
        begin
            ignored_sent++;
        end
    endtask

    // Hold the sender until every outstanding distance has come back
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        burst_left = 0;
    endtask

    function automatic logic [7:0] random_byte();
        case ($urandom_range(0, 3))
            0:       return 8'($urandom_range(UPPER_A, UPPER_Z));
            1:       return 8'($urandom_range(UPPER_A, UPPER_Z)) | CASE_BIT;
            // neighbors of the letter ranges that differ only in the case bit
            2:       return ($urandom_range(0, 1) ? 8'h40 : 8'h5B)
                            | ($urandom_range(0, 1) ? CASE_BIT : 8'h00);
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic int pick_length();
        if ($urandom_range(0, 24) == 0)
        begin
            return $urandom_range(MAX_LEN - 1, MAX_LEN + 2);
        end
        return $urandom_range(0, 12);
    endfunction

    task automatic send_pair(input int n1, input int n2, input bit noisy);
        logic [7:0] first_str [MAX_LEN + 4];
        logic [7:0] ch;
        logic [1:0] noise_act;
        int         i;
        for (i = 0; i < n1; i++)
        begin
            first_str[i] = random_byte();
            put_item(ACT_LOAD, first_str[i], 1'b1);
            if (noisy && $urandom_range(0, 5) == 0)
            begin
                put_item(ACT_UNUSED, 8'($urandom_range(0, 255)), 1'b0);
            end
        end
        for (i = 0; i < n2; i++)
        begin
            // Mostly echo the first string, sometimes with the case flipped
            if (n1 > 0 && $urandom_range(0, 2) != 0)
            begin
                ch = first_str[i % n1];
                if (((ch >= UPPER_A && ch <= UPPER_Z)
                     || (ch >= (UPPER_A | CASE_BIT) && ch <= (UPPER_Z | CASE_BIT)))
                    && $urandom_range(0, 1))
                begin
                    ch = ch ^ CASE_BIT;
                end
            end
            else
            begin
                ch = random_byte();
            end
            put_item(ACT_CMP, ch, 1'b1);
            if (noisy && $urandom_range(0, 3) == 0)
            begin
                if ($urandom_range(0, 1))
                begin
                    noise_act = ACT_LOAD;
                end
                else
                begin
                    noise_act = ACT_UNUSED;
                end
                put_item(noise_act, 8'($urandom_range(0, 255)), 1'b0);
            end
        end
        put_item(ACT_FIN, 8'($urandom_range(0, 255)), 1'b1);
        pairs_sent++;
    endtask

    // Receiver: random readiness whose density is redrawn from a fixed set of levels as the run goes on,
    // plus a long hold-off on request
    initial
    begin
        int pct;
        int tick;
        m_tready = 1'b0;
        pct      = 100;
        tick     = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                if (tick % 256 == 0)
                begin
                    case ($urandom_range(0, 4))
                        0, 1:    pct = 100;
                        2:       pct = 75;
                        3:       pct = 40;
                        default: pct = 10;
                    endcase
                end
                tick++;
                m_tready <= ($urandom_range(1, 100) <= pct);
                @(posedge clk);
            end
        end
    end

    initial
    begin
        int n1;
        int n2;
        int set_no;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = 8'h00;
        s_tuser      = ACT_LOAD;
        rx_hold_req  = 1'b0;
        burst_left   = 0;
        items_sent   = 0;
        ignored_sent = 0;
        pairs_sent   = 0;
        set_no       = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Both strings empty
        put_item(ACT_FIN, 8'hFF, 1'b1);
        // Letters match across case
        put_item(ACT_LOAD, 8'h41, 1'b1);
        put_item(ACT_LOAD, 8'h7A, 1'b1);
        put_item(ACT_CMP, 8'h61, 1'b1);
        put_item(ACT_CMP, 8'h5A, 1'b1);
        put_item(ACT_FIN, 8'h00, 1'b1);
        // Non-letters next to A-Z and a-z do not fold
        put_item(ACT_LOAD, 8'h40, 1'b1);
        put_item(ACT_LOAD, 8'h5B, 1'b1);
        put_item(ACT_CMP, 8'h60, 1'b1);
        put_item(ACT_CMP, 8'h7B, 1'b1);
        put_item(ACT_FIN, 8'h55, 1'b1);
        // First string only
        put_item(ACT_LOAD, 8'h00, 1'b1);
        put_item(ACT_LOAD, 8'hFF, 1'b1);
        put_item(ACT_FIN, 8'hAA, 1'b1);
        // Second string only, with a late load and the unused code dropped
        put_item(ACT_CMP, 8'hFF, 1'b1);
        put_item(ACT_CMP, 8'h00, 1'b1);
        put_item(ACT_LOAD, 8'h41, 1'b0);
        put_item(ACT_CMP, 8'hC1, 1'b1);
        put_item(ACT_UNUSED, 8'hAA, 1'b0);
        put_item(ACT_FIN, 8'h0F, 1'b1);
        // High bytes are not letters
        put_item(ACT_LOAD, 8'hDA, 1'b1);
        put_item(ACT_CMP, 8'hFA, 1'b1);
        put_item(ACT_FIN, 8'hF0, 1'b1);
        wait_results_drained();

        while (items_sent < ITEM_TARGET)
        begin
            case (set_no)
                0:
                begin
                    n1 = MAX_LEN + 2;
                    n2 = 3;
                end
                1:
                begin
                    n1 = 2;
                    n2 = MAX_LEN + 3;
                end
                2:
                begin
                    n1 = 0;
                    n2 = MAX_LEN;
                end
                3:
                begin
                    n1 = MAX_LEN;
                    n2 = MAX_LEN;
                end
                default:
                begin
                    n1 = pick_length();
                    n2 = pick_length();
                end
            endcase
            if (set_no == 8 || set_no == 90)
            begin
                rx_hold_req = 1'b1;
            end
            if (set_no % 40 == 20)
            begin
                wait_results_drained();
            end
            send_pair(n1, n2, $urandom_range(0, 7) == 0);
            set_no++;
        end

        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (MAX_LEN + 16) @(posedge clk);

        $display("run: %0d transfers over %0d string pairs, %0d more that the block ignores",
                 items_sent, pairs_sent, ignored_sent);
        $display("run: %0d distances checked, %0d of them with the overflow flag",
                 results_checked, overflow_results);
        if (errors == 0)
        begin
            $display("[case_insensitive_edit_distance] OK");
        end
        else
        begin
            $display("[case_insensitive_edit_distance] ERROR");
        end
        $finish;
    end

    initial
    begin
        #(LIMIT_CYCLES * 10);
        $display("[case_insensitive_edit_distance] ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
src/cied_pkg.sv
src/cied_cell.sv
src/case_insensitive_edit_distance.sv
verif/edit_distance_checker.sv
verif/case_insensitive_edit_distance_test.sv
